[design/timed_event_order_queue_top_assert.svh]
`ifndef TIMED_EVENT_ORDER_QUEUE_TOP_ASSERT_SVH
`define TIMED_EVENT_ORDER_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TEOQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TEOQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/teoq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package teoq_pkg;

   localparam int TIME_W = 64;
   localparam int KIND_W = 3;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;

   localparam logic [TIME_W-1:0] TIME_NONE = {TIME_W{1'b1}};

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SPAN_BEGIN   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SPAN_END     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REGION_BEGIN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REGION_END   = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL         = 2'd1;
   localparam logic [STAT_W-1:0] ST_POP_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] ST_REGION_NO_TM = 2'd3;

   typedef struct packed {
      logic insert;
      logic pop;
   } teoq_ctl_type;

   typedef struct packed {
      logic [TIME_W-1:0] ev_time;
      logic [KIND_W-1:0] kind;
   } teoq_entry_type;

endpackage

`default_nettype wire

[design/teoq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module teoq_cell
   import teoq_pkg::*;
#(
   parameter int TAG_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire teoq_ctl_type         ctl,
   input  wire logic                 occupied,
   input  wire logic                 left_shift,
   input  wire teoq_entry_type       new_entry,
   input  wire logic [TAG_WIDTH-1:0] new_tag,
   input  wire teoq_entry_type       left_entry,
   input  wire logic [TAG_WIDTH-1:0] left_tag,
   input  wire teoq_entry_type       right_entry,
   input  wire logic [TAG_WIDTH-1:0] right_tag,
   output logic                      shift_out,
   output teoq_entry_type            entry,
   output logic [TAG_WIDTH-1:0]      tag
);

   teoq_entry_type       entry_ff, entry_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 goes_before;

   // The queue is sorted, so this flag reads 0 ... 0 1 ... 1 along the row;
   // the first cell that raises it is where the new event lands.
   always_comb begin
      if (new_entry.ev_time != entry_ff.ev_time) begin
         goes_before = new_entry.ev_time < entry_ff.ev_time;
      end else if (new_entry.kind == KIND_REGION_BEGIN) begin
         goes_before = 1'b1;
      end else if (new_entry.kind == KIND_REGION_END) begin
         goes_before = 1'b0;
      end else begin
         goes_before = entry_ff.kind != KIND_REGION_BEGIN;
      end
   end

   assign shift_out = !occupied || goes_before;

   always_comb begin
      entry_in = entry_ff;
      tag_in   = tag_ff;
      if (ctl.insert && shift_out) begin
         if (left_shift) begin
            entry_in = left_entry;
            tag_in   = left_tag;
         end else begin
            entry_in = new_entry;
            tag_in   = new_tag;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
         tag_in   = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tag_ff   <= tag_in;
   end

   assign entry = entry_ff;
   assign tag   = tag_ff;

endmodule

`default_nettype wire

[design/timed_event_order_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_ready  op, time, kind, tag
// rsp      out        rsp_valid/rsp_ready  popped event, interval, empty flag, status
//
// For every request, all cells compare the new time against their
// own entry in parallel and the row shifts by one place on insert or pop.
// The result beat is registered; a new request is taken while the result
// register is empty or being drained: one beat per cycle while rsp_ready is high.
// Reset (synchronous) empties the queue and forgets the last popped time.
module timed_event_order_queue_top
   import teoq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_WIDTH   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_op,
   input  wire logic [TIME_W-1:0]    req_in_time,
   input  wire logic [KIND_W-1:0]    req_in_kind,
   input  wire logic [TAG_WIDTH-1:0] req_in_tag,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_ev_valid,
   output logic [TIME_W-1:0]         rsp_out_time,
   output logic [KIND_W-1:0]         rsp_out_kind,
   output logic [TAG_WIDTH-1:0]      rsp_out_tag,
   output logic                      rsp_span_valid,
   output logic [TIME_W-1:0]         rsp_span_start,
   output logic [TIME_W-1:0]         rsp_span_stop,
   output logic                      rsp_queue_empty,
   output logic [STAT_W-1:0]         rsp_status
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              rsp_valid_ff;

   logic                 ev_valid_ff, ev_valid_in;
   logic [TIME_W-1:0]    out_time_ff, out_time_in;
   logic [KIND_W-1:0]    out_kind_ff, out_kind_in;
   logic [TAG_WIDTH-1:0] out_tag_ff, out_tag_in;
   logic                 span_valid_ff, span_valid_in;
   logic [TIME_W-1:0]    span_start_ff, span_start_in;
   logic [TIME_W-1:0]    span_stop_ff, span_stop_in;
   logic                 empty_ff, empty_in;
   logic [STAT_W-1:0]    status_ff, status_in;

   logic           accept;
   logic           is_full;
   logic           is_empty;
   logic           drop;
   teoq_ctl_type   ctl;
   teoq_entry_type new_entry;

   teoq_entry_type       cell_entry [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0] cell_tag   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_shift;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = count_ff == CNT_W'(QUEUE_DEPTH);
   assign is_empty  = count_ff == '0;

   always_comb begin
      new_entry.kind    = req_in_kind;
      new_entry.ev_time = req_in_time;
      drop              = 1'b0;
      case (req_in_kind)
         KIND_SPAN_BEGIN, KIND_REGION_BEGIN: begin
            if (req_in_time == TIME_NONE) begin
               new_entry.ev_time = '0;
            end
         end
         KIND_SPAN_END: begin
            if (req_in_time != TIME_NONE) begin
               new_entry.ev_time = req_in_time - TIME_W'(1);
            end
         end
         KIND_REGION_END: begin
            drop = req_in_time == TIME_NONE;
         end
         default: begin
         end
      endcase
   end

   assign ctl.insert = accept && (req_op == OP_INSERT) && !drop && !is_full;
   assign ctl.pop    = accept && (req_op == OP_POP) && !is_empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

      teoq_cell #(
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (CNT_W'(i) < count_ff),
         .left_shift ((i == 0) ? 1'b0 : cell_shift[LEFT]),
         .new_entry  (new_entry),
         .new_tag    (req_in_tag),
         .left_entry (cell_entry[LEFT]),
         .left_tag   (cell_tag[LEFT]),
         .right_entry(cell_entry[RIGHT]),
         .right_tag  (cell_tag[RIGHT]),
         .shift_out  (cell_shift[i]),
         .entry      (cell_entry[i]),
         .tag        (cell_tag[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      last_time_in  = last_time_ff;
      ev_valid_in   = 1'b0;
      out_time_in   = '0;
      out_kind_in   = '0;
      out_tag_in    = '0;
      span_valid_in = 1'b0;
      span_start_in = '0;
      span_stop_in  = '0;
      status_in     = ST_OK;
      case (req_op)
         OP_INSERT: begin
            if (drop) begin
               status_in = ST_REGION_NO_TM;
            end else if (is_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (is_empty) begin
               status_in = ST_POP_EMPTY;
            end else begin
               ev_valid_in  = 1'b1;
               out_time_in  = cell_entry[0].ev_time;
               out_kind_in  = cell_entry[0].kind;
               out_tag_in   = cell_tag[0];
               if (last_time_ff != TIME_NONE && last_time_ff != cell_entry[0].ev_time) begin
                  span_valid_in = 1'b1;
                  span_start_in = last_time_ff;
                  span_stop_in  = cell_entry[0].ev_time;
               end
               last_time_in = cell_entry[0].ev_time;
               count_in     = count_ff - CNT_W'(1);
            end
         end
         OP_CLOSE: begin
            if (last_time_ff != TIME_NONE) begin
               span_valid_in = 1'b1;
               span_start_in = last_time_ff;
               span_stop_in  = last_time_ff + TIME_W'(1);
            end
            last_time_in = TIME_NONE;
            count_in     = '0;
         end
         default: begin
         end
      endcase
      empty_in = count_in == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_time_ff <= TIME_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            last_time_ff <= last_time_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev_valid_ff   <= ev_valid_in;
         out_time_ff   <= out_time_in;
         out_kind_ff   <= out_kind_in;
         out_tag_ff    <= out_tag_in;
         span_valid_ff <= span_valid_in;
         span_start_ff <= span_start_in;
         span_stop_ff  <= span_stop_in;
         empty_ff      <= empty_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ev_valid    = ev_valid_ff;
   assign rsp_out_time    = out_time_ff;
   assign rsp_out_kind    = out_kind_ff;
   assign rsp_out_tag     = out_tag_ff;
   assign rsp_span_valid  = span_valid_ff;
   assign rsp_span_start  = span_start_ff;
   assign rsp_span_stop   = span_stop_ff;
   assign rsp_queue_empty = empty_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

[design/teoq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "timed_event_order_queue_top_assert.svh"

module teoq_checker
   import teoq_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [OP_W-1:0]      req_op,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_ev_valid,
   input wire logic [TIME_W-1:0]    rsp_out_time,
   input wire logic                 rsp_span_valid,
   input wire logic [TIME_W-1:0]    rsp_span_start,
   input wire logic [TIME_W-1:0]    rsp_span_stop,
   input wire logic                 rsp_queue_empty,
   input wire logic [STAT_W-1:0]    rsp_status
);

   // A stalled result beat must hold.
   `TEOQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_time) && $stable(rsp_status))

   // A returned event always comes with a clean status.
   `TEOQ_ASSERT_IMPL(a_ev_ok, clock, reset, rsp_valid && rsp_ev_valid, rsp_status == ST_OK)

   // A pop on an empty queue returns nothing and leaves the queue empty.
   `TEOQ_ASSERT_IMPL(a_pop_empty, clock, reset, rsp_valid && rsp_status == ST_POP_EMPTY, rsp_queue_empty && !rsp_ev_valid && !rsp_span_valid)

   // An interval on a pop always ends at the popped time.
   `TEOQ_ASSERT_IMPL(a_span_stop, clock, reset, rsp_valid && rsp_ev_valid && rsp_span_valid, rsp_span_stop == rsp_out_time && rsp_span_start != rsp_out_time)

   // A close is answered in the next cycle and flushes the queue.
   `TEOQ_ASSERT_NEXT(a_close_flush, clock, reset, req_valid && req_ready && req_op == OP_CLOSE, rsp_valid && rsp_queue_empty && !rsp_ev_valid)

endmodule

bind timed_event_order_queue_top teoq_checker u_teoq_checker (.*);

`default_nettype wire
